/* rtl/ifa_pkg.sv */
// ifa_pkg: command, compare mode and float constants for the alu
// no dependencies
package ifa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_AND  = 4'd2,
    CMD_OR   = 4'd3,
    CMD_XOR  = 4'd4,
    CMD_SLL  = 4'd5,
    CMD_SRL  = 4'd6,
    CMD_SRA  = 4'd7,
    CMD_CMPS = 4'd8,
    CMD_CMPU = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    CMP_LT = 2'b00,
    CMP_EQ = 2'b01,
    CMP_NE = 2'b10,
    CMP_GE = 2'b11
  } cmp_e;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [3:0]  cmd;
    logic        is_float;
    logic [1:0]  compare_mode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } req_t;

endpackage

/* rtl/ifa_fadd.sv */
// ifa_fadd: single precision add, round to nearest even, subnormals kept
// depends on ifa_pkg
module ifa_fadd (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] sum_o
);
  import ifa_pkg::*;

  logic [7:0]  ea, eb, ex, ey;
  logic [22:0] ma, mb;
  logic [26:0] sa, sb, sx, sy, sy_sh;
  logic        swap, sgn_x, sgn_y, sticky;
  logic [7:0]  d;
  logic [27:0] s;
  logic [26:0] sn;
  logic [8:0]  e, en;
  logic [4:0]  lz, shamt;
  logic [24:0] r;
  logic [2:0]  grs;
  logic [8:0]  ef;

  always_comb begin
    ea = a_i[30:23];
    eb = b_i[30:23];
    ma = a_i[22:0];
    mb = b_i[22:0];
    sa = {(ea != 8'd0), ma, 3'b000};
    sb = {(eb != 8'd0), mb, 3'b000};
    if (ea == 8'd0) ea = 8'd1;
    if (eb == 8'd0) eb = 8'd1;
    swap  = (eb > ea) || ((eb == ea) && (sb > sa));
    ex    = swap ? eb : ea;
    ey    = swap ? ea : eb;
    sx    = swap ? sb : sa;
    sy    = swap ? sa : sb;
    sgn_x = swap ? b_i[31] : a_i[31];
    sgn_y = swap ? a_i[31] : b_i[31];
    d = ex - ey;
    sticky = 1'b0;
    if (d >= 8'd27) begin
      sy_sh = {26'd0, (sy != 27'd0)};
    end else begin
      sticky = ((sy & ((27'd1 << d[4:0]) - 27'd1)) != 27'd0);
      sy_sh  = (sy >> d[4:0]) | {26'd0, sticky};
    end
    e = {1'b0, ex};
    s = '0;
    if (sgn_x == sgn_y) begin
      s = {1'b0, sx} + {1'b0, sy_sh};
      if (s[27]) begin
        s = {1'b0, s[27:2], s[1] | s[0]};
        e = e + 9'd1;
      end
    end else begin
      s = {1'b0, sx} - {1'b0, sy_sh};
    end
    sn = s[26:0];
    lz = 5'd26;
    for (int i = 0; i <= 26; i++) begin
      if (sn[i]) lz = 5'(26 - i);
    end
    shamt = 5'd0;
    if (sgn_x != sgn_y) begin
      shamt = ({4'd0, lz} < (e - 9'd1)) ? lz : 5'(e - 9'd1);
      sn = sn << shamt;
      en = e - {4'd0, shamt};
    end else begin
      en = e;
    end
    grs = sn[2:0];
    r = {1'b0, sn[26:3]};
    if (grs > 3'd4 || (grs == 3'd4 && r[0])) r = r + 25'd1;
    ef = en;
    if (r[24]) begin
      r  = r >> 1;
      ef = ef + 9'd1;
    end

    if ((a_i[30:23] == 8'hFF && ma != 23'd0) || (b_i[30:23] == 8'hFF && mb != 23'd0)) begin
      sum_o = QNAN;
    end else if (a_i[30:23] == 8'hFF) begin
      sum_o = (b_i[30:23] == 8'hFF && a_i[31] != b_i[31]) ? QNAN : a_i;
    end else if (b_i[30:23] == 8'hFF) begin
      sum_o = b_i;
    end else if (sgn_x != sgn_y && s == 28'd0) begin
      sum_o = 32'd0;
    end else if (ef >= 9'd255) begin
      sum_o = {sgn_x, 31'h7F80_0000};
    end else begin
      sum_o = {sgn_x, (r[23] ? ef[7:0] : 8'd0), r[22:0]};
    end
  end

endmodule

/* rtl/ifa_exec.sv */
// ifa_exec: integer ops, compares and float add/sub selection
// depends on ifa_pkg and ifa_fadd
module ifa_exec (
  input  ifa_pkg::req_t req_i,
  input  logic [31:0]   prev_i,
  output logic [31:0]   result_o
);
  import ifa_pkg::*;

  logic [31:0] a, b, fsum, ca, cb;
  logic [4:0]  sh;
  logic        cr;

  assign a  = req_i.operand_a;
  assign b  = req_i.operand_b;
  assign sh = b[4:0];

  ifa_fadd u_fadd (
    .a_i  (a),
    .b_i  ({b[31] ^ (req_i.cmd == CMD_SUB), b[30:0]}),
    .sum_o(fsum)
  );

  always_comb begin
    ca = (req_i.cmd == CMD_CMPS) ? {~a[31], a[30:0]} : a;
    cb = (req_i.cmd == CMD_CMPS) ? {~b[31], b[30:0]} : b;
    case (cmp_e'(req_i.compare_mode))
      CMP_LT:  cr = ca < cb;
      CMP_EQ:  cr = ca == cb;
      CMP_NE:  cr = ca != cb;
      default: cr = ca >= cb;
    endcase
    result_o = prev_i;
    if (req_i.is_float) begin
      if (req_i.cmd == CMD_ADD || req_i.cmd == CMD_SUB) result_o = fsum;
    end else begin
      case (req_i.cmd)
        CMD_ADD:  result_o = a + b;
        CMD_SUB:  result_o = a - b;
        CMD_AND:  result_o = a & b;
        CMD_OR:   result_o = a | b;
        CMD_XOR:  result_o = a ^ b;
        CMD_SLL:  result_o = a << sh;
        CMD_SRL:  result_o = a >> sh;
        CMD_SRA:  result_o = 32'($signed(a) >>> sh);
        CMD_CMPS, CMD_CMPU: result_o = {31'd0, cr};
        default:  result_o = prev_i;
      endcase
    end
  end

endmodule

/* rtl/int_and_fp32_add_alu.sv */
// int_and_fp32_add_alu: top level, input register, execute logic, output register
// depends on ifa_pkg and ifa_exec
//
// channel  dir  fields
// s_axis   in   tdata: cmd, is_float, compare_mode, operand_a, operand_b
// m_axis   out  tdata: result
//
// one request per cycle while m_axis does not stall; a request is held in the input
// register, and its result is then loaded into the output register
// a stall on m_axis holds both stages; the input stage refills when it moves
// reset clears valid flags and the held result to zero
module int_and_fp32_add_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // cmd[3:0], is_float, compare_mode[1:0], a, b, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // result
);
  import ifa_pkg::*;

  req_t        req_q;
  logic        in_vld_q, out_vld_q;
  logic [31:0] last_q, res_d;
  logic        out_move, in_move;

  assign out_move      = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || out_move;
  assign in_move       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = last_q;

  ifa_exec u_exec (
    .req_i   (req_q),
    .prev_i  (last_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      last_q    <= '0;
    end else begin
      if (in_move) in_vld_q <= 1'b1;
      else if (out_move) in_vld_q <= 1'b0;
      if (out_move) begin
        out_vld_q <= 1'b1;
        last_q    <= res_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      req_q.cmd          <= s_axis_tdata[3:0];
      req_q.is_float     <= s_axis_tdata[4];
      req_q.compare_mode <= s_axis_tdata[6:5];
      req_q.operand_a    <= s_axis_tdata[38:7];
      req_q.operand_b    <= s_axis_tdata[70:39];
    end
  end

endmodule
